>>> rtl/acoustic_riemann_face_solver_defines.svh
// Assertion macros for the acoustic face solver.
`ifndef ACOUSTIC_RIEMANN_FACE_SOLVER_DEFINES_SVH
`define ACOUSTIC_RIEMANN_FACE_SOLVER_DEFINES_SVH

// Check a consequence in the same cycle.
`define ARFS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("face solver check failed");

// Check a consequence in the next cycle.
`define ARFS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("face solver check failed");

`endif

>>> rtl/arfs_pkg.sv
// Types and constants shared by the acoustic face solver.
package arfs_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int MAX_STRIDE = 1024;
  localparam int STRIDE_W   = 11;
  localparam int PTR_W      = $clog2(MAX_STRIDE);
  localparam int FILL_W     = $clog2(MAX_STRIDE + 1);
  localparam int LINE_W     = 4 * DATA_WIDTH;
  localparam int Z_W        = 2 * DATA_WIDTH;
  localparam int ZZ_W       = 4 * DATA_WIDTH;
  localparam int ACC_W      = 5 * DATA_WIDTH + 2;
  localparam int MUL_W      = 2 * DATA_WIDTH + 1;
  localparam int REM_W      = 2 * DATA_WIDTH + 2;
  localparam int CNT_W      = $clog2(MUL_W);

  typedef struct packed {
    logic [DATA_WIDTH-1:0]        density;
    logic [DATA_WIDTH-1:0]        sound_speed;
    logic signed [DATA_WIDTH-1:0] velocity;
    logic signed [DATA_WIDTH-1:0] pressure;
    logic                         sweep_start;
  } in_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] face_velocity;
    logic signed [DATA_WIDTH-1:0] face_pressure;
    logic                         saturated;
    logic                         zero_impedance;
  } out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_MAC,
    S_DIV_LOAD,
    S_DIV_CHECK,
    S_DIV,
    S_OUT
  } state_t;

  typedef enum logic [3:0] {
    ST_ZI,
    ST_ZM,
    ST_U1,
    ST_U2,
    ST_U3,
    ST_ZZ,
    ST_P1,
    ST_P2,
    ST_P3
  } step_t;

endpackage

>>> rtl/acoustic_riemann_face_solver.sv
// Acoustic Godunov face solver: delay line, bit-serial multiply-accumulate, radix-2 divide.
//
// Input channel in_valid/in_stall/in_data carries one cell per beat; the output channel
// out_valid/out_stall/out_data carries one face result per beat. A beat moves at a clock
// edge with valid high and stall low. config_write/config_data set the stride; the user
// must write it only while idle, the block itself does not enforce this. A cell whose sweep
// has fewer than stride earlier cells gives no result and leaves the solver idle. Any other
// cell passes a shift-and-add multiplier that retires one multiplier bit per cycle over nine
// products, each after a setup step, and a restoring divider that retires one quotient bit
// per cycle for each of the two quotients (one that would overflow saturates), and S_OUT hands
// the beat to the output register. A zero impedance sum ends after the two impedances.
// in_stall is high from acceptance until the result enters the output register, so the
// next cell is taken while a finished result still waits there. When the receiver stalls,
// the output register holds its beat and a following result waits in the solver.
// Synchronous reset sets stride to 1 and clears the line pointer, the fill count, the
// state machine and out_valid; the delay line itself is not cleared.
`include "acoustic_riemann_face_solver_defines.svh"

module acoustic_riemann_face_solver (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  config_write,
  input  logic [arfs_pkg::STRIDE_W-1:0]         config_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  arfs_pkg::in_t                         in_data,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output arfs_pkg::out_t                        out_data
);

  localparam int W = arfs_pkg::DATA_WIDTH;

  logic [arfs_pkg::STRIDE_W-1:0] stride;
  logic [arfs_pkg::STRIDE_W-1:0] stride_eff;
  logic [arfs_pkg::PTR_W-1:0]    line_pointer;
  logic [arfs_pkg::PTR_W-1:0]    rd_addr;
  logic [arfs_pkg::FILL_W:0]     ptr_ext;
  logic [arfs_pkg::FILL_W:0]     stride_ext;
  logic [arfs_pkg::FILL_W-1:0]   fill_count;
  logic [arfs_pkg::FILL_W-1:0]   fill_base;
  logic                          accept;
  logic                          produce;

  logic [arfs_pkg::LINE_W-1:0]   line_mem [arfs_pkg::MAX_STRIDE];
  logic [arfs_pkg::LINE_W-1:0]   rd_line;
  logic [W-1:0]                  up_density;
  logic [W-1:0]                  up_speed;
  logic [W-1:0]                  up_velocity;
  logic [W-1:0]                  up_pressure;
  arfs_pkg::in_t                 cur_cell;

  arfs_pkg::state_t              state;
  arfs_pkg::state_t              state_next;
  arfs_pkg::step_t               step;
  arfs_pkg::step_t               step_next;

  logic [arfs_pkg::ACC_W-1:0]    acc;
  logic [arfs_pkg::ACC_W-1:0]    mcand;
  logic [arfs_pkg::MUL_W-1:0]    mplier;
  logic [arfs_pkg::CNT_W-1:0]    count;
  logic [arfs_pkg::Z_W-1:0]      zi;
  logic [arfs_pkg::Z_W-1:0]      zm;
  logic [arfs_pkg::ZZ_W-1:0]     zz;
  logic [arfs_pkg::MUL_W-1:0]    den;
  logic [arfs_pkg::REM_W-1:0]    rem;
  logic [W-1:0]                  quo;
  logic                          sign;
  logic [W-1:0]                  fv;
  logic [W-1:0]                  fp;
  logic                          sat;
  logic                          zero;

  logic [arfs_pkg::ACC_W-1:0]    op_mcand;
  logic [arfs_pkg::MUL_W-1:0]    op_mplier;
  logic                          op_clear;
  logic                          mac_last;
  logic [arfs_pkg::ACC_W-1:0]    mac_sum;
  logic                          den_zero;
  logic [arfs_pkg::ACC_W-1:0]    mag;
  logic [arfs_pkg::ACC_W-W-1:0]  div_hi;
  logic                          div_ovf;
  logic [arfs_pkg::REM_W-1:0]    div_try;
  logic                          div_ge;
  logic [arfs_pkg::REM_W-1:0]    div_rem;
  logic [W-1:0]                  div_quo;
  logic                          div_last;
  logic [W:0]                    fix;
  logic                          fix_store;
  logic                          out_load;

  function automatic logic [arfs_pkg::MUL_W-1:0] sext(input logic [W-1:0] v);
    return {{(arfs_pkg::MUL_W-W){v[W-1]}}, v};
  endfunction

  function automatic logic [W:0] fix_result(input logic neg, input logic ovf,
                                            input logic [W-1:0] q);
    logic [W-1:0] min_mag;
    logic         clip;
    min_mag = {1'b1, {(W-1){1'b0}}};
    clip    = ovf || (neg ? (q > min_mag) : q[W-1]);
    if (clip) begin
      return {1'b1, neg ? min_mag : ~min_mag};
    end
    return {1'b0, neg ? (~q + W'(1)) : q};
  endfunction

  // stride handling and delay-line bookkeeping
  always_comb begin
    if (stride == '0) begin
      stride_eff = arfs_pkg::STRIDE_W'(1);
    end else if (stride > arfs_pkg::STRIDE_W'(arfs_pkg::MAX_STRIDE)) begin
      stride_eff = arfs_pkg::STRIDE_W'(arfs_pkg::MAX_STRIDE);
    end else begin
      stride_eff = stride;
    end
    ptr_ext    = (arfs_pkg::FILL_W+1)'(line_pointer);
    stride_ext = (arfs_pkg::FILL_W+1)'(stride_eff);
    if (ptr_ext >= stride_ext) begin
      rd_addr = arfs_pkg::PTR_W'(ptr_ext - stride_ext);
    end else begin
      rd_addr = arfs_pkg::PTR_W'(ptr_ext + (arfs_pkg::FILL_W+1)'(arfs_pkg::MAX_STRIDE)
                                 - stride_ext);
    end
    fill_base = in_data.sweep_start ? '0 : fill_count;
    produce   = fill_base >= arfs_pkg::FILL_W'(stride_eff);
  end

  assign in_stall = (state != arfs_pkg::S_IDLE);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      stride       <= arfs_pkg::STRIDE_W'(1);
      line_pointer <= '0;
      fill_count   <= '0;
    end else begin
      if (config_write) begin
        stride <= config_data;
      end
      if (accept) begin
        if (line_pointer == arfs_pkg::PTR_W'(arfs_pkg::MAX_STRIDE - 1)) begin
          line_pointer <= '0;
        end else begin
          line_pointer <= line_pointer + arfs_pkg::PTR_W'(1);
        end
        if (fill_base < arfs_pkg::FILL_W'(arfs_pkg::MAX_STRIDE)) begin
          fill_count <= fill_base + arfs_pkg::FILL_W'(1);
        end else begin
          fill_count <= fill_base;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      line_mem[line_pointer] <= {in_data.density, in_data.sound_speed,
                                 in_data.velocity, in_data.pressure};
      rd_line  <= line_mem[rd_addr];
      cur_cell <= in_data;
    end
  end

  assign up_density  = rd_line[4*W-1:3*W];
  assign up_speed    = rd_line[3*W-1:2*W];
  assign up_velocity = rd_line[2*W-1:W];
  assign up_pressure = rd_line[W-1:0];

  // operands of each product
  always_comb begin
    op_mcand  = '0;
    op_mplier = '0;
    op_clear  = 1'b0;
    case (step)
      arfs_pkg::ST_ZI: begin
        op_mcand  = arfs_pkg::ACC_W'(cur_cell.density);
        op_mplier = arfs_pkg::MUL_W'(cur_cell.sound_speed);
        op_clear  = 1'b1;
      end
      arfs_pkg::ST_ZM: begin
        op_mcand  = arfs_pkg::ACC_W'(up_density);
        op_mplier = arfs_pkg::MUL_W'(up_speed);
        op_clear  = 1'b1;
      end
      arfs_pkg::ST_U1: begin
        op_mcand  = arfs_pkg::ACC_W'(zm);
        op_mplier = sext(up_velocity);
        op_clear  = 1'b1;
      end
      arfs_pkg::ST_U2: begin
        op_mcand  = arfs_pkg::ACC_W'(zi);
        op_mplier = sext(cur_cell.velocity);
      end
      arfs_pkg::ST_U3: begin
        op_mcand  = arfs_pkg::ACC_W'(1) << W;
        op_mplier = sext(up_pressure) - sext(cur_cell.pressure);
      end
      arfs_pkg::ST_ZZ: begin
        op_mcand  = arfs_pkg::ACC_W'(zm);
        op_mplier = arfs_pkg::MUL_W'(zi);
        op_clear  = 1'b1;
      end
      arfs_pkg::ST_P1: begin
        op_mcand  = arfs_pkg::ACC_W'(zz);
        op_mplier = sext(up_velocity) - sext(cur_cell.velocity);
        op_clear  = 1'b1;
      end
      arfs_pkg::ST_P2: begin
        op_mcand  = arfs_pkg::ACC_W'(zi) << W;
        op_mplier = sext(up_pressure);
      end
      arfs_pkg::ST_P3: begin
        op_mcand  = arfs_pkg::ACC_W'(zm) << W;
        op_mplier = sext(cur_cell.pressure);
      end
      default: begin
        op_mcand  = '0;
        op_mplier = '0;
        op_clear  = 1'b0;
      end
    endcase
  end

  // multiply-accumulate and divide steps
  always_comb begin
    mac_last = (count == ((step == arfs_pkg::ST_ZZ) ? arfs_pkg::CNT_W'(arfs_pkg::MUL_W - 1)
                                                     : arfs_pkg::CNT_W'(W)));
    if (mplier[0]) begin
      mac_sum = mac_last ? (acc - mcand) : (acc + mcand);
    end else begin
      mac_sum = acc;
    end
    den_zero = (zi == '0) && (mac_sum[arfs_pkg::Z_W-1:0] == '0);
    mag      = acc[arfs_pkg::ACC_W-1] ? (~acc + arfs_pkg::ACC_W'(1)) : acc;
    div_hi   = mcand[arfs_pkg::ACC_W-1:W];
    div_ovf  = div_hi >= (arfs_pkg::ACC_W-W)'(den);
    div_try  = {rem[arfs_pkg::REM_W-2:0], mcand[W-1]};
    div_ge   = div_try >= arfs_pkg::REM_W'(den);
    div_rem  = div_ge ? (div_try - arfs_pkg::REM_W'(den)) : div_try;
    div_quo  = {quo[W-2:0], div_ge};
    div_last = (count == arfs_pkg::CNT_W'(W - 1));
    fix      = fix_result(sign, state == arfs_pkg::S_DIV_CHECK, div_quo);
    fix_store = ((state == arfs_pkg::S_DIV_CHECK) && div_ovf) ||
                ((state == arfs_pkg::S_DIV) && div_last);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= arfs_pkg::S_IDLE;
      step  <= arfs_pkg::ST_ZI;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    out_load   = 1'b0;
    case (state)
      arfs_pkg::S_IDLE: begin
        if (accept && produce) begin
          state_next = arfs_pkg::S_SETUP;
          step_next  = arfs_pkg::ST_ZI;
        end
      end
      arfs_pkg::S_SETUP: begin
        state_next = arfs_pkg::S_MAC;
      end
      arfs_pkg::S_MAC: begin
        if (mac_last) begin
          state_next = arfs_pkg::S_SETUP;
          case (step)
            arfs_pkg::ST_ZI: step_next = arfs_pkg::ST_ZM;
            arfs_pkg::ST_ZM: begin
              if (den_zero) begin
                state_next = arfs_pkg::S_OUT;
              end else begin
                step_next = arfs_pkg::ST_U1;
              end
            end
            arfs_pkg::ST_U1: step_next = arfs_pkg::ST_U2;
            arfs_pkg::ST_U2: step_next = arfs_pkg::ST_U3;
            arfs_pkg::ST_ZZ: step_next = arfs_pkg::ST_P1;
            arfs_pkg::ST_P1: step_next = arfs_pkg::ST_P2;
            arfs_pkg::ST_P2: step_next = arfs_pkg::ST_P3;
            default: state_next = arfs_pkg::S_DIV_LOAD;
          endcase
        end
      end
      arfs_pkg::S_DIV_LOAD: begin
        state_next = arfs_pkg::S_DIV_CHECK;
      end
      arfs_pkg::S_DIV_CHECK, arfs_pkg::S_DIV: begin
        if (fix_store) begin
          if (step == arfs_pkg::ST_U3) begin
            state_next = arfs_pkg::S_SETUP;
            step_next  = arfs_pkg::ST_ZZ;
          end else begin
            state_next = arfs_pkg::S_OUT;
          end
        end else begin
          state_next = arfs_pkg::S_DIV;
        end
      end
      arfs_pkg::S_OUT: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = arfs_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = arfs_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      arfs_pkg::S_SETUP: begin
        mcand  <= op_mcand;
        mplier <= op_mplier;
        count  <= '0;
        if (op_clear) begin
          acc <= '0;
        end
      end
      arfs_pkg::S_MAC: begin
        acc    <= mac_sum;
        mcand  <= mcand << 1;
        mplier <= mplier >> 1;
        count  <= count + arfs_pkg::CNT_W'(1);
        if (mac_last) begin
          case (step)
            arfs_pkg::ST_ZI: zi <= mac_sum[arfs_pkg::Z_W-1:0];
            arfs_pkg::ST_ZM: begin
              zm   <= mac_sum[arfs_pkg::Z_W-1:0];
              den  <= arfs_pkg::MUL_W'(zi) + arfs_pkg::MUL_W'(mac_sum[arfs_pkg::Z_W-1:0]);
              fv   <= '0;
              fp   <= '0;
              sat  <= 1'b0;
              zero <= den_zero;
            end
            arfs_pkg::ST_ZZ: zz <= mac_sum[arfs_pkg::ZZ_W-1:0];
            default: ;
          endcase
        end
      end
      arfs_pkg::S_DIV_LOAD: begin
        sign  <= acc[arfs_pkg::ACC_W-1];
        mcand <= (step == arfs_pkg::ST_P3) ? (mag >> W) : mag;
      end
      arfs_pkg::S_DIV_CHECK: begin
        rem   <= arfs_pkg::REM_W'(div_hi);
        quo   <= '0;
        count <= '0;
      end
      arfs_pkg::S_DIV: begin
        rem   <= div_rem;
        quo   <= div_quo;
        mcand <= mcand << 1;
        count <= count + arfs_pkg::CNT_W'(1);
      end
      default: ;
    endcase
    if (fix_store) begin
      if (step == arfs_pkg::ST_U3) begin
        fv <= fix[W-1:0];
      end else begin
        fp <= fix[W-1:0];
      end
      sat <= sat | fix[W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.face_velocity  <= fv;
      out_data.face_pressure  <= fp;
      out_data.saturated      <= sat;
      out_data.zero_impedance <= zero;
    end
  end

  `ARFS_ASSERT_NOW(a_zero_forces_zero, out_valid && out_data.zero_impedance,
    out_data.face_velocity == '0 && out_data.face_pressure == '0 && !out_data.saturated)
  `ARFS_ASSERT_NEXT(a_no_result_idle, accept && !produce, state == arfs_pkg::S_IDLE)
  `ARFS_ASSERT_NOW(a_rem_below_den, state == arfs_pkg::S_DIV, rem < arfs_pkg::REM_W'(den))

endmodule
